// ===== hw/rtl/pgtu_pkg.sv =====
// shared constants, types and helper functions of the page table updater
`timescale 1ns / 1ps
package pgtu_pkg;

  localparam int TABLE_FRAMES = 16;
  localparam int FRM_W        = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
  localparam int FCNT_W       = $clog2(TABLE_FRAMES + 1);
  localparam int IDX_W        = 9;
  localparam int MEM_AW       = FRM_W + IDX_W;
  localparam int MEM_DEPTH    = TABLE_FRAMES * 512;

  localparam logic OP_MAP   = 1'b0;
  localparam logic OP_UNMAP = 1'b1;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_NO_ROOT   = 3'd1;
  localparam logic [2:0] ST_OUTSIDE   = 3'd2;
  localparam logic [2:0] ST_NO_FRAMES = 3'd3;
  localparam logic [2:0] ST_NOT_MAPPED = 3'd4;

  // datapath command codes
  localparam logic [4:0] CMD_NOP     = 5'd0;
  localparam logic [4:0] CMD_CLR     = 5'd1;
  localparam logic [4:0] CMD_ROOT    = 5'd2;
  localparam logic [4:0] CMD_RD      = 5'd3;
  localparam logic [4:0] CMD_LATCH   = 5'd4;
  localparam logic [4:0] CMD_DESCEND = 5'd5;
  localparam logic [4:0] CMD_LVL0    = 5'd6;
  localparam logic [4:0] CMD_SCAN    = 5'd7;
  localparam logic [4:0] CMD_FILLZ   = 5'd8;
  localparam logic [4:0] CMD_FILLS   = 5'd9;
  localparam logic [4:0] CMD_WPTR    = 5'd10;
  localparam logic [4:0] CMD_WPTRS   = 5'd11;
  localparam logic [4:0] CMD_WLEAF   = 5'd12;
  localparam logic [4:0] CMD_WZERO   = 5'd13;
  localparam logic [4:0] CMD_RDSCAN  = 5'd14;
  localparam logic [4:0] CMD_CNTINC  = 5'd15;
  localparam logic [4:0] CMD_FREE    = 5'd16;
  localparam logic [4:0] CMD_FIN     = 5'd17;

  localparam logic [63:0] KEEP_FLAGS = 64'h8000_0000_0000_001F;

  typedef logic [FRM_W-1:0] frame_t;

  typedef struct packed {
    logic [4:0] op;
    logic       rdy;
    logic [1:0] need;
    logic [2:0] st;
  } pgtu_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       in_valid;
    logic       op;
    logic       root_zero;
    logic       root_ok;
    logic       e_present;
    logic       e_huge;
    logic       e_ok;
    logic [1:0] lvl;
    logic       free_zero;
    logic       free_ge;
    logic       sc_free;
    logic       cnt_last;
    logic       q_present;
    logic       out_free;
  } pgtu_sts_t;

  function automatic logic frame_ok(input logic [51:0] addr, input logic [51:0] base);
    logic [39:0] d;
    d = addr[51:12] - base[51:12];
    return (addr[51:12] >= base[51:12]) && (d < 40'(TABLE_FRAMES));
  endfunction

  function automatic frame_t frame_idx(input logic [51:0] addr, input logic [51:0] base);
    logic [39:0] d;
    d = addr[51:12] - base[51:12];
    return d[FRM_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/pgtu_if.sv =====
// request and result channel interfaces
`timescale 1ns / 1ps
interface pgtu_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [47:0] virt_addr;
  logic [51:0] phys_addr;
  logic [11:0] page_flags;
  logic        no_execute;
  logic [51:0] root_addr;
  modport source(output valid, op, virt_addr, phys_addr, page_flags, no_execute, root_addr,
                 input ready);
  modport sink(input valid, op, virt_addr, phys_addr, page_flags, no_execute, root_addr,
               output ready);
endinterface

interface pgtu_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       invalidate_page;
  logic       full_flush;
  logic [1:0] tables_freed;
  modport source(output valid, status, invalidate_page, full_flush, tables_freed,
                 input ready);
  modport sink(input valid, status, invalidate_page, full_flush, tables_freed,
               output ready);
endinterface

// ===== hw/rtl/four_level_page_table_updater_core.sv =====
// Four-level page table updater: map and unmap requests over a pool of table frames.
// Requests enter on in_ch (valid/ready); each gives one result on out_ch.
// A map walks the four levels, allocates and zeroes missing tables (lowest
// free frame first) and splits 1G/2M huge entries into 512 smaller ones.
// An unmap clears the leaf and frees tables that become empty, bottom-up.
// A map through tables that are all present walks them twice, once to count
// the frames needed and once to write; each allocated or split table adds a
// scan for the lowest free frame and a fill of all 512 of its entries. An unmap
// walks down, then reads the leaf table entry by entry until a present one is
// found; a table with none is freed, and its parent is checked the same way.
// The table memory is single-ported and reads or writes one entry per cycle.
// One request is in flight at a time; the next is accepted once the result
// is registered, while that result waits to be taken.
// A stalled receiver holds the result; the block finishes the next request
// and waits until the output register is free.
// After reset the block clears the whole table memory, one entry a cycle, and
// accepts no request until then; configuration writes over psel/penable are
// taken at any time.
`timescale 1ns / 1ps
module four_level_page_table_updater_core import pgtu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pgtu_in_if.sink     in_ch,
  pgtu_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  pgtu_cmd_t cmd;
  pgtu_sts_t sts;

  pgtu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  pgtu_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

endmodule

// ===== hw/rtl/pgtu_dp.sv =====
// datapath: table memory, frame allocator, walk registers and config registers
`timescale 1ns / 1ps
module pgtu_dp import pgtu_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  pgtu_cmd_t     cmd,
  output pgtu_sts_t     sts,
  pgtu_in_if.sink       in_ch,
  pgtu_out_if.source    out_ch,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  logic [51:0] kroot_r, tbase_r;
  logic        op_r;
  logic [47:0] va_r;
  logic [63:0] leaf_r, e_r, mem_q_r;
  logic [51:0] root_r;
  frame_t      fr_r [4];
  frame_t      new_r, sc_r;
  logic [1:0]  lvl_r;
  logic [8:0]  cnt_r;
  logic [MEM_AW-1:0] clr_r;
  logic [TABLE_FRAMES-1:0] in_use_r;
  logic [FCNT_W-1:0] free_r;
  logic        flush_r;
  logic [1:0]  freed_r;
  logic        out_valid_r;
  logic [2:0]  status_r;
  logic        inv_r, fflush_r;
  logic [1:0]  tfreed_r;

  logic [63:0] mem [MEM_DEPTH];

  logic        acc;
  logic [8:0]  ix;
  frame_t      cur_fr;
  logic [MEM_AW-1:0] walk_a, mem_a;
  logic        mem_we;
  logic [63:0] mem_wd, split_val, ptr_val, split_base, split_fl;
  logic [39:0] new_ptr;

  assign acc = in_ch.valid & cmd.rdy;
  assign in_ch.ready = cmd.rdy;
  assign pready = 1'b1;
  assign prdata = paddr[3] ? {12'b0, tbase_r} : {12'b0, kroot_r};

  always_comb begin
    case (lvl_r)
      2'd0:    ix = va_r[47:39];
      2'd1:    ix = va_r[38:30];
      2'd2:    ix = va_r[29:21];
      default: ix = va_r[20:12];
    endcase
  end

  assign cur_fr  = fr_r[lvl_r];
  assign walk_a  = {cur_fr, ix};
  assign new_ptr = tbase_r[51:12] + 40'(new_r);
  assign ptr_val = {12'b0, new_ptr, 12'h007};

  // 1G entries split into 2M huge entries, 2M entries into 4K pages
  assign split_base = (lvl_r == 2'd1) ? (e_r & ~64'h3FFF_FFFF) : (e_r & ~64'h1F_FFFF);
  assign split_fl   = (e_r & KEEP_FLAGS) | ((lvl_r == 2'd1) ? 64'h80 : 64'h0);
  assign split_val  = (split_base + ((lvl_r == 2'd1) ? (64'(cnt_r) << 21) : (64'(cnt_r) << 12)))
                      | split_fl;

  always_comb begin
    mem_we = 1'b0;
    mem_wd = '0;
    mem_a  = walk_a;
    unique case (cmd.op)
      CMD_CLR: begin
        mem_we = 1'b1;
        mem_a  = clr_r;
      end
      CMD_RDSCAN: mem_a = {cur_fr, cnt_r};
      CMD_FILLZ: begin
        mem_we = 1'b1;
        mem_a  = {new_r, cnt_r};
      end
      CMD_FILLS: begin
        mem_we = 1'b1;
        mem_a  = {new_r, cnt_r};
        mem_wd = split_val;
      end
      CMD_WPTR, CMD_WPTRS: begin
        mem_we = 1'b1;
        mem_wd = ptr_val;
      end
      CMD_WLEAF: begin
        mem_we = 1'b1;
        mem_wd = leaf_r;
      end
      CMD_WZERO: mem_we = 1'b1;
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_a] <= mem_wd;
    end
    mem_q_r <= mem[mem_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kroot_r     <= '0;
      tbase_r     <= 52'h0_0000_0010_0000;
      lvl_r       <= '0;
      sc_r        <= '0;
      cnt_r       <= '0;
      clr_r       <= '0;
      in_use_r    <= TABLE_FRAMES'(1);
      free_r      <= FCNT_W'(TABLE_FRAMES - 1);
      flush_r     <= 1'b0;
      freed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[3]) begin
          tbase_r <= pwdata[51:0];
        end else begin
          kroot_r <= pwdata[51:0];
        end
      end
      if (acc) begin
        flush_r <= 1'b0;
        freed_r <= '0;
      end
      if (cmd.op == CMD_FIN) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        CMD_CLR:              clr_r <= clr_r + 1'b1;
        CMD_ROOT, CMD_LVL0:   lvl_r <= '0;
        CMD_DESCEND:          lvl_r <= lvl_r + 2'd1;
        CMD_SCAN: begin
          if (!in_use_r[sc_r]) begin
            in_use_r[sc_r] <= 1'b1;
            free_r         <= free_r - 1'b1;
            sc_r           <= '0;
          end else begin
            sc_r <= sc_r + 1'b1;
          end
        end
        CMD_FILLZ, CMD_FILLS, CMD_CNTINC: cnt_r <= cnt_r + 9'd1;
        CMD_WPTRS:            flush_r <= 1'b1;
        CMD_FREE: begin
          // a frame never marked in use is not counted back
          if (in_use_r[cur_fr]) begin
            in_use_r[cur_fr] <= 1'b0;
            free_r           <= free_r + 1'b1;
          end
          lvl_r   <= lvl_r - 2'd1;
          freed_r <= freed_r + 2'd1;
        end
        CMD_FIN: begin
          cnt_r <= '0;
          sc_r  <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r   <= in_ch.op;
      va_r   <= in_ch.virt_addr;
      leaf_r <= {in_ch.no_execute, 11'b0, in_ch.phys_addr[51:12], in_ch.page_flags};
      root_r <= (in_ch.root_addr != '0) ? in_ch.root_addr : kroot_r;
    end
    case (cmd.op)
      CMD_ROOT:    fr_r[0] <= frame_idx(root_r, tbase_r);
      CMD_LATCH:   e_r <= mem_q_r;
      CMD_DESCEND: fr_r[lvl_r + 2'd1] <= frame_idx(e_r[51:0], tbase_r);
      CMD_SCAN:    new_r <= sc_r;
      CMD_WPTR, CMD_WPTRS: e_r <= ptr_val;
      CMD_FIN: begin
        status_r <= cmd.st;
        inv_r    <= (cmd.st == ST_DONE);
        fflush_r <= flush_r;
        tfreed_r <= (cmd.st == ST_DONE) ? freed_r : 2'd0;
      end
      default: ;
    endcase
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = status_r;
  assign out_ch.invalidate_page = inv_r;
  assign out_ch.full_flush      = fflush_r;
  assign out_ch.tables_freed    = tfreed_r;

  always_comb begin
    sts.clr_done  = (clr_r == MEM_AW'(MEM_DEPTH - 1));
    sts.in_valid  = in_ch.valid;
    sts.op        = op_r;
    sts.root_zero = (root_r == '0);
    sts.root_ok   = frame_ok(root_r, tbase_r);
    sts.e_present = e_r[0];
    sts.e_huge    = e_r[7];
    sts.e_ok      = frame_ok(e_r[51:0], tbase_r);
    sts.lvl       = lvl_r;
    sts.free_zero = (free_r == '0);
    sts.free_ge   = ((FCNT_W + 2)'(free_r) >= (FCNT_W + 2)'(cmd.need));
    sts.sc_free   = !in_use_r[sc_r];
    sts.cnt_last  = (cnt_r == 9'd511);
    sts.q_present = mem_q_r[0];
    sts.out_free  = !out_valid_r || out_ch.ready;
  end

endmodule

// ===== hw/rtl/pgtu_ctrl.sv =====
// controller: sequences table walks, splits, allocation and empty-table checks
`timescale 1ns / 1ps
module pgtu_ctrl import pgtu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  pgtu_sts_t sts,
  output pgtu_cmd_t cmd
);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_ROOT = 5'd2;
  localparam logic [4:0] S_CRD  = 5'd3;
  localparam logic [4:0] S_CLT  = 5'd4;
  localparam logic [4:0] S_CEV  = 5'd5;
  localparam logic [4:0] S_FCK  = 5'd6;
  localparam logic [4:0] S_WRD  = 5'd7;
  localparam logic [4:0] S_WLT  = 5'd8;
  localparam logic [4:0] S_WEV  = 5'd9;
  localparam logic [4:0] S_SSC  = 5'd10;
  localparam logic [4:0] S_SFL  = 5'd11;
  localparam logic [4:0] S_SPT  = 5'd12;
  localparam logic [4:0] S_ASC  = 5'd13;
  localparam logic [4:0] S_AFL  = 5'd14;
  localparam logic [4:0] S_APT  = 5'd15;
  localparam logic [4:0] S_LEAF = 5'd16;
  localparam logic [4:0] S_URD  = 5'd17;
  localparam logic [4:0] S_ULT  = 5'd18;
  localparam logic [4:0] S_UEV  = 5'd19;
  localparam logic [4:0] S_ERD  = 5'd20;
  localparam logic [4:0] S_ECK  = 5'd21;
  localparam logic [4:0] S_FREE = 5'd22;
  localparam logic [4:0] S_ZERO = 5'd23;
  localparam logic [4:0] S_FIN  = 5'd24;

  logic [4:0] state_r, state_nxt;
  logic [1:0] need_r, need_nxt;
  logic [2:0] st_r, st_nxt;

  always_comb begin
    cmd       = '0;
    cmd.need  = need_r;
    cmd.st    = st_r;
    state_nxt = state_r;
    need_nxt  = need_r;
    st_nxt    = st_r;
    unique case (state_r)
      S_CLR: begin
        cmd.op = CMD_CLR;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.rdy = 1'b1;
        if (sts.in_valid) state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (sts.root_zero) begin
          st_nxt = ST_NO_ROOT; state_nxt = S_FIN;
        end else if (!sts.root_ok) begin
          st_nxt = ST_OUTSIDE; state_nxt = S_FIN;
        end else begin
          cmd.op    = CMD_ROOT;
          state_nxt = (sts.op == OP_UNMAP) ? S_URD : S_CRD;
        end
      end
      // map, first pass: count the frames needed
      S_CRD: begin
        cmd.op = CMD_RD; state_nxt = S_CLT;
      end
      S_CLT: begin
        cmd.op = CMD_LATCH; state_nxt = S_CEV;
      end
      S_CEV: begin
        if (sts.lvl == 2'd2) begin
          if (sts.e_present && !sts.e_huge) begin
            if (!sts.e_ok) begin
              st_nxt = ST_OUTSIDE; state_nxt = S_FIN;
            end else begin
              need_nxt = 2'd0; state_nxt = S_FCK;
            end
          end else begin
            need_nxt = 2'd1; state_nxt = S_FCK;
          end
        end else if (!sts.e_present || (sts.lvl == 2'd1 && sts.e_huge)) begin
          need_nxt  = (sts.lvl == 2'd0) ? 2'd3 : 2'd2;
          state_nxt = S_FCK;
        end else if (!sts.e_ok) begin
          st_nxt = ST_OUTSIDE; state_nxt = S_FIN;
        end else begin
          cmd.op = CMD_DESCEND; state_nxt = S_CRD;
        end
      end
      S_FCK: begin
        if (!sts.free_ge) begin
          st_nxt = ST_NO_FRAMES; state_nxt = S_FIN;
        end else begin
          cmd.op = CMD_LVL0; state_nxt = S_WRD;
        end
      end
      // map, second pass: split, allocate, descend
      S_WRD: begin
        cmd.op = CMD_RD; state_nxt = S_WLT;
      end
      S_WLT: begin
        cmd.op = CMD_LATCH; state_nxt = S_WEV;
      end
      S_WEV: begin
        if (sts.lvl != 2'd0 && sts.e_present && sts.e_huge) begin
          if (sts.free_zero) begin
            st_nxt = ST_NO_FRAMES; state_nxt = S_FIN;
          end else begin
            state_nxt = S_SSC;
          end
        end else if (!sts.e_present) begin
          if (sts.free_zero) begin
            st_nxt = ST_NO_FRAMES; state_nxt = S_FIN;
          end else begin
            state_nxt = S_ASC;
          end
        end else if (!sts.e_ok) begin
          st_nxt = ST_OUTSIDE; state_nxt = S_FIN;
        end else begin
          cmd.op    = CMD_DESCEND;
          state_nxt = (sts.lvl == 2'd2) ? S_LEAF : S_WRD;
        end
      end
      S_SSC: begin
        cmd.op = CMD_SCAN;
        if (sts.sc_free) state_nxt = S_SFL;
      end
      S_SFL: begin
        cmd.op = CMD_FILLS;
        if (sts.cnt_last) state_nxt = S_SPT;
      end
      S_SPT: begin
        cmd.op = CMD_WPTRS; state_nxt = S_WEV;
      end
      S_ASC: begin
        cmd.op = CMD_SCAN;
        if (sts.sc_free) state_nxt = S_AFL;
      end
      S_AFL: begin
        cmd.op = CMD_FILLZ;
        if (sts.cnt_last) state_nxt = S_APT;
      end
      S_APT: begin
        cmd.op = CMD_WPTR; state_nxt = S_WEV;
      end
      S_LEAF: begin
        cmd.op = CMD_WLEAF; st_nxt = ST_DONE; state_nxt = S_FIN;
      end
      // unmap walk
      S_URD: begin
        cmd.op = CMD_RD; state_nxt = S_ULT;
      end
      S_ULT: begin
        cmd.op = CMD_LATCH; state_nxt = S_UEV;
      end
      S_UEV: begin
        if (!sts.e_present || (sts.lvl != 2'd0 && sts.lvl != 2'd3 && sts.e_huge)) begin
          st_nxt = ST_NOT_MAPPED; state_nxt = S_FIN;
        end else if (sts.lvl == 2'd3) begin
          cmd.op = CMD_WZERO; state_nxt = S_ERD;
        end else if (!sts.e_ok) begin
          st_nxt = ST_OUTSIDE; state_nxt = S_FIN;
        end else begin
          cmd.op = CMD_DESCEND; state_nxt = S_URD;
        end
      end
      // empty check of the current table, entry by entry
      S_ERD: begin
        cmd.op = CMD_RDSCAN; state_nxt = S_ECK;
      end
      S_ECK: begin
        if (sts.q_present) begin
          st_nxt = ST_DONE; state_nxt = S_FIN;
        end else begin
          cmd.op    = CMD_CNTINC;
          state_nxt = sts.cnt_last ? S_FREE : S_ERD;
        end
      end
      S_FREE: begin
        cmd.op = CMD_FREE; state_nxt = S_ZERO;
      end
      S_ZERO: begin
        cmd.op = CMD_WZERO;
        if (sts.lvl == 2'd0) begin
          st_nxt = ST_DONE; state_nxt = S_FIN;
        end else begin
          state_nxt = S_ERD;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.op = CMD_FIN; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      need_r  <= '0;
      st_r    <= ST_DONE;
    end else begin
      state_r <= state_nxt;
      need_r  <= need_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

// ===== hw/rtl/pgtu_chk.sv =====
// port-level checker for the page table updater, bound to the top level
`timescale 1ns / 1ps
module pgtu_chk import pgtu_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic       invalidate_page,
  input logic [1:0] tables_freed
);

  // a waiting result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

  // one request at a time: no second request right after one is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (invalidate_page == (status == ST_DONE)))
    else $error("invalidate does not match status");

  a_freed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_DONE |-> tables_freed == 2'd0)
    else $error("tables freed on failed request");

endmodule

bind four_level_page_table_updater_core pgtu_chk u_pgtu_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .status          (out_ch.status),
  .invalidate_page (out_ch.invalidate_page),
  .tables_freed    (out_ch.tables_freed)
);
